>>> rtl/stl_pkg.sv
// Shared types and codes for the source text lexer.
package stl_pkg;

    localparam logic [3:0] M_IDLE         = 4'd0;
    localparam logic [3:0] M_WORD         = 4'd1;
    localparam logic [3:0] M_SPACE        = 4'd2;
    localparam logic [3:0] M_STR_OPEN     = 4'd3;
    localparam logic [3:0] M_STR_BODY     = 4'd4;
    localparam logic [3:0] M_SLASH        = 4'd5;
    localparam logic [3:0] M_LINE         = 4'd6;
    localparam logic [3:0] M_BLOCK        = 4'd7;
    localparam logic [3:0] M_BLOCK_DOLLAR = 4'd8;
    localparam logic [3:0] M_HELD         = 4'd9;
    localparam logic [3:0] M_DEC          = 4'd10;
    localparam logic [3:0] M_HEX          = 4'd11;
    localparam logic [3:0] M_BIN          = 4'd12;

    localparam logic [3:0] K_WORD  = 4'd0;
    localparam logic [3:0] K_SPACE = 4'd1;
    localparam logic [3:0] K_QUOTE = 4'd2;
    localparam logic [3:0] K_BODY  = 4'd3;
    localparam logic [3:0] K_BREAK = 4'd4;
    localparam logic [3:0] K_DELIM = 4'd5;
    localparam logic [3:0] K_DEC   = 4'd6;
    localparam logic [3:0] K_HEX   = 4'd7;
    localparam logic [3:0] K_BIN   = 4'd8;
    localparam logic [3:0] K_OTHER = 4'd9;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] kind;
        logic       start;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
        logic [3:0] mode;
        logic [7:0] held;
    } step_t;

endpackage

>>> rtl/source_text_lexer.sv
// Top level of the streaming source text lexer.
// One text byte is taken per cycle on the slave side; s_tlast marks the end of
// the text. Each byte yields zero, one or two result words, which wait in a
// four-entry queue; the input is taken whenever the queue has room for two more.
// Sustained rate is one byte per cycle while each byte yields at most one word
// and the output is ready, and the single output port, one word per cycle, sets
// the rate when a byte after a held digit yields two.
module source_text_lexer
    import stl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [7:0] m_tuser,   // [3:0] token_kind, [4] token_start, [7:5] zero
    output logic       m_tlast    // last_of_item
);

    logic [3:0] mode_reg;
    logic [7:0] held_reg;
    step_t      step;
    logic       accept;
    res_t       head;

    assign accept = s_tvalid && s_tready;

    stl_step u_step (
        .mode        (mode_reg),
        .held        (held_reg),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .step        (step)
    );

    stl_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .step      (step),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (head)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            held_reg <= '0;
        end else if (accept) begin
            mode_reg <= step.mode;
            held_reg <= step.held;
        end
    end

    assign m_tdata = head.data;
    assign m_tuser = {3'b000, head.start, head.kind};
    assign m_tlast = head.last;

    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> mode_reg == M_IDLE)
        else $error("end of text did not return to idle");

    a_held_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && mode_reg == M_HELD |-> step.count != 2'd0)
        else $error("held digit not released");

    a_comment_open: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_tlast && mode_reg == M_SLASH && s_tdata == CH_SLASH
        |-> step.count == 2'd0 ##1 mode_reg == M_LINE)
        else $error("line comment not entered");

endmodule

>>> rtl/stl_step.sv
// Next-mode and result logic for one input word of the lexer.
module stl_step
    import stl_pkg::*;
(
    input  logic [3:0] mode,
    input  logic [7:0] held,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output step_t      step
);

    typedef struct packed {
        logic       valid;
        res_t       r;
        logic [3:0] mode;
        logic       hold;
    } fresh_t;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = c inside {[8'h30:8'h39]};
    endfunction

    function automatic fresh_t lex_fresh(input logic [7:0] c);
        fresh_t f;
        f         = '0;
        f.r.data  = c;
        f.r.start = 1'b1;
        f.mode    = M_IDLE;
        f.valid   = 1'b1;
        if (c == CH_SLASH) begin
            f.valid = 1'b0;
            f.mode  = M_SLASH;
        end else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
            f.r.kind = K_WORD;
            f.mode   = M_WORD;
        end else if (c == CH_SPACE) begin
            f.r.kind = K_SPACE;
            f.mode   = M_SPACE;
        end else if (c == CH_QUOTE) begin
            f.r.kind = K_QUOTE;
            f.mode   = M_STR_OPEN;
        end else if (c == CH_LF) begin
            f.r.kind = K_BREAK;
        end else if (c inside {[8'h27:8'h2E], 8'h3A, 8'h3B}) begin
            f.r.kind = K_DELIM;
        end else if (is_digit(c)) begin
            f.valid = 1'b0;
            f.hold  = 1'b1;
            f.mode  = M_HELD;
        end else begin
            f.r.kind = K_OTHER;
        end
        return f;
    endfunction

    fresh_t fr;
    res_t   cur;
    res_t   hd;

    always_comb begin
        fr        = lex_fresh(text_byte);
        cur       = '0;
        cur.data  = text_byte;
        hd        = '0;
        hd.data   = held;
        hd.start  = 1'b1;
        step      = '0;
        step.mode = mode;
        step.held = held;
        if (end_of_text) begin
            if (mode == M_HELD) begin
                hd.kind    = K_DEC;
                step.r0    = hd;
                step.count = 2'd1;
            end
            step.mode = M_IDLE;
        end else begin
            case (mode)
                M_WORD, M_SPACE, M_DEC, M_HEX, M_BIN: begin
                    if ((mode == M_WORD && text_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]})
                        || (mode == M_SPACE && text_byte == CH_SPACE)
                        || (mode == M_DEC && is_digit(text_byte))
                        || (mode == M_HEX && text_byte inside
                            {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]})
                        || (mode == M_BIN && (text_byte == CH_ZERO || text_byte == CH_ONE)))
                    begin
                        case (mode)
                            M_WORD:  cur.kind = K_WORD;
                            M_SPACE: cur.kind = K_SPACE;
                            M_DEC:   cur.kind = K_DEC;
                            M_HEX:   cur.kind = K_HEX;
                            default: cur.kind = K_BIN;
                        endcase
                        step.r0    = cur;
                        step.count = 2'd1;
                    end else begin
                        step.r0    = fr.r;
                        step.count = {1'b0, fr.valid};
                        step.mode  = fr.mode;
                        if (fr.hold) begin
                            step.held = text_byte;
                        end
                    end
                end
                M_STR_OPEN, M_STR_BODY: begin
                    if (text_byte == CH_QUOTE) begin
                        cur.kind  = K_QUOTE;
                        cur.start = 1'b1;
                        step.mode = M_IDLE;
                    end else begin
                        cur.kind  = K_BODY;
                        cur.start = (mode == M_STR_OPEN);
                        step.mode = M_STR_BODY;
                    end
                    step.r0    = cur;
                    step.count = 2'd1;
                end
                M_SLASH: begin
                    if (text_byte == CH_SLASH) begin
                        step.mode = M_LINE;
                    end else if (text_byte == CH_DOLLAR) begin
                        step.mode = M_BLOCK;
                    end else begin
                        step.r0    = fr.r;
                        step.count = {1'b0, fr.valid};
                        step.mode  = fr.mode;
                        if (fr.hold) begin
                            step.held = text_byte;
                        end
                    end
                end
                M_LINE: begin
                    if (text_byte == CH_LF) begin
                        cur.kind   = K_BREAK;
                        cur.start  = 1'b1;
                        step.r0    = cur;
                        step.count = 2'd1;
                        step.mode  = M_IDLE;
                    end
                end
                M_BLOCK: begin
                    if (text_byte == CH_DOLLAR) begin
                        step.mode = M_BLOCK_DOLLAR;
                    end
                end
                M_BLOCK_DOLLAR: begin
                    if (text_byte == CH_SLASH) begin
                        step.mode = M_IDLE;
                    end else if (text_byte != CH_DOLLAR) begin
                        step.mode = M_BLOCK;
                    end
                end
                M_HELD: begin
                    if (text_byte == CH_X) begin
                        hd.kind    = K_HEX;
                        cur.kind   = K_HEX;
                        step.r0    = hd;
                        step.r1    = cur;
                        step.count = 2'd2;
                        step.mode  = M_HEX;
                    end else if (text_byte == CH_B) begin
                        hd.kind    = K_BIN;
                        cur.kind   = K_BIN;
                        step.r0    = hd;
                        step.r1    = cur;
                        step.count = 2'd2;
                        step.mode  = M_BIN;
                    end else if (is_digit(text_byte)) begin
                        hd.kind    = K_DEC;
                        cur.kind   = K_DEC;
                        step.r0    = hd;
                        step.r1    = cur;
                        step.count = 2'd2;
                        step.mode  = M_DEC;
                    end else begin
                        hd.kind    = K_DEC;
                        step.r0    = hd;
                        step.r1    = fr.r;
                        step.count = fr.valid ? 2'd2 : 2'd1;
                        step.mode  = fr.mode;
                        if (fr.hold) begin
                            step.held = text_byte;
                        end
                    end
                end
                default: begin
                    step.r0    = fr.r;
                    step.count = {1'b0, fr.valid};
                    step.mode  = fr.mode;
                    if (fr.hold) begin
                        step.held = text_byte;
                    end
                end
            endcase
        end
        // flag the final result of this word
        if (step.count == 2'd2) begin
            step.r1.last = 1'b1;
        end else if (step.count == 2'd1) begin
            step.r0.last = 1'b1;
        end
    end

endmodule

>>> rtl/stl_fifo.sv
// Four-entry result queue taking up to two words per cycle and giving one while the reader is ready.
module stl_fifo
    import stl_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  step_t step,
    output logic  space,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    res_t       mem_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] level_reg;
    logic [1:0] n_push;
    logic       pop;

    assign n_push    = push ? step.count : 2'd0;
    assign out_valid = (level_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign out_res   = mem_reg[rd_ptr_reg];
    assign space     = (level_reg <= 3'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + n_push;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            level_reg  <= level_reg + {1'b0, n_push} - {2'b00, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            mem_reg[wr_ptr_reg] <= step.r0;
        end
        if (n_push == 2'd2) begin
            mem_reg[wr_ptr_reg + 2'd1] <= step.r1;
        end
    end

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= 3'd4)
        else $error("result queue overfilled");

endmodule
